// File: hw/rtl/rgb24_to_yuv420_converter_macros.svh
// Assertion macros shared by the RGB24 to YUV 4:2:0 converter modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef RGB24_TO_YUV420_CONVERTER_MACROS_SVH
`define RGB24_TO_YUV420_CONVERTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RGB2YUV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb2yuv assertion failed");

// Next-cycle implication, checked outside reset.
`define RGB2YUV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb2yuv assertion failed");

`endif

// File: hw/rtl/rgb2yuv_pkg.sv
// Types, constants and conversion functions of the RGB24 to YUV 4:2:0 converter.
// Depends on nothing; imported by every module of the block.
package rgb2yuv_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int MIN_DIMENSION = 2;
    localparam int DIM_W         = 13;
    localparam int COUNT_W       = 12;
    localparam int CFG_INDEX_W   = 2;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = 2;
    localparam int FIFO_CW       = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        PLANE_Y  = 2'd0,
        PLANE_CB = 2'd1,
        PLANE_CR = 2'd2
    } plane_t;

    // One classified pixel as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       has_chroma;
        logic       even_row;
        logic       eof;
    } pixel_item_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v < DIM_W'(MIN_DIMENSION))
            res = DIM_W'(MIN_DIMENSION);
        else if (v > DIM_W'(MAX_DIMENSION))
            res = DIM_W'(MAX_DIMENSION);
        else
            res = v;
        return res;
    endfunction

    function automatic logic [7:0] calc_luma(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        logic [16:0] s;
        s = 17'd66 * 17'(r) + 17'd129 * 17'(g) + 17'd25 * 17'(b) + 17'd128;
        return s[15:8] + 8'd16;
    endfunction

    // The offset 32896 is 128 * 256 + 128; it keeps the sum positive so that the
    // upper byte is the floored quotient plus 128.
    function automatic logic [7:0] calc_chroma(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic even_row);
        logic [16:0] s;
        if (even_row)
            s = 17'd112 * 17'(b) + 17'd32896 - 17'd38 * 17'(r) - 17'd74 * 17'(g);
        else
            s = 17'd112 * 17'(r) + 17'd32896 - 17'd94 * 17'(g) - 17'd18 * 17'(b);
        return s[15:8];
    endfunction

endpackage

// File: hw/rtl/rgb2yuv_front.sv
// Front end: frame size registers, column and row counters, pixel classification.
// Depends on rgb2yuv_pkg.
module rgb2yuv_front
    import rgb2yuv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    input  logic                   queue_full,
    output logic                   push,
    output pixel_item_t            push_item
);

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COUNT_W-1:0] col_reg;
    logic [COUNT_W-1:0] col_next;
    logic [COUNT_W-1:0] row_reg;
    logic [COUNT_W-1:0] row_next;
    logic               row_end;
    logic               last_row;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // A counter at or past the last index counts as on it, so a mid-frame size
    // change still ends the row or frame cleanly.
    assign row_end  = (DIM_W'(col_reg) + DIM_W'(1)) >= clamp_dim(width_reg);
    assign last_row = (DIM_W'(row_reg) + DIM_W'(1)) >= clamp_dim(height_reg);

    always_comb
    begin
        push_item.red        = red;
        push_item.green      = green;
        push_item.blue       = blue;
        push_item.has_chroma = !col_reg[0];
        push_item.even_row   = !row_reg[0];
        push_item.eof        = row_end && last_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + COUNT_W'(1);
            end
            else
            begin
                col_next = col_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(256);
            height_reg <= DIM_W'(256);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

endmodule

// File: hw/rtl/rgb2yuv_queue.sv
// Short queue of classified pixels between the front and back ends.
// Depends on rgb2yuv_pkg and the assertion macro header.
`include "rgb24_to_yuv420_converter_macros.svh"

module rgb2yuv_queue
    import rgb2yuv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pixel_item_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output pixel_item_t head_item
);

    pixel_item_t        entries [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    assign full       = count_reg == FIFO_CW'(FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + FIFO_CW'(1);
        else if (pop && !push)
            count_next = count_reg - FIFO_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_item;
    end

    `RGB2YUV_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= FIFO_CW'(FIFO_DEPTH))
    `RGB2YUV_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, head_valid)
    `RGB2YUV_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + FIFO_CW'(1))

endmodule

// File: hw/rtl/rgb2yuv_back.sv
// Back end: color conversion and result sequencing, luma then optional chroma.
// Depends on rgb2yuv_pkg and the assertion macro header.
`include "rgb24_to_yuv420_converter_macros.svh"

module rgb2yuv_back
    import rgb2yuv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  pixel_item_t head_item,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  plane,
    output logic [7:0]  sample_value,
    output logic        last_of_pixel,
    output logic        end_of_frame
);

    logic       busy_reg;
    logic       busy_next;
    logic       chroma_phase_reg;
    logic       chroma_phase_next;
    logic [7:0] luma_reg;
    logic [7:0] chroma_reg;
    logic       has_chroma_reg;
    logic       even_row_reg;
    logic       eof_reg;
    logic       last_now;
    logic       out_xfer;
    plane_t     plane_sel;

    assign last_now = chroma_phase_reg || !has_chroma_reg;
    assign out_xfer = busy_reg && out_ready;
    // The next pixel loads as soon as the final result of the current one leaves.
    assign pop      = head_valid && (!busy_reg || (out_ready && last_now));

    always_comb
    begin
        busy_next         = busy_reg;
        chroma_phase_next = chroma_phase_reg;
        if (pop)
        begin
            busy_next         = 1'b1;
            chroma_phase_next = 1'b0;
        end
        else if (out_xfer)
        begin
            if (last_now)
                busy_next = 1'b0;
            else
                chroma_phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            chroma_phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            chroma_phase_reg <= chroma_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            luma_reg       <= calc_luma(head_item.red, head_item.green, head_item.blue);
            chroma_reg     <= calc_chroma(head_item.red, head_item.green, head_item.blue,
                                          head_item.even_row);
            has_chroma_reg <= head_item.has_chroma;
            even_row_reg   <= head_item.even_row;
            eof_reg        <= head_item.eof;
        end
    end

    always_comb
    begin
        if (!chroma_phase_reg)
            plane_sel = PLANE_Y;
        else if (even_row_reg)
            plane_sel = PLANE_CB;
        else
            plane_sel = PLANE_CR;
    end

    assign out_valid     = busy_reg;
    assign plane         = plane_sel;
    assign sample_value  = chroma_phase_reg ? chroma_reg : luma_reg;
    assign last_of_pixel = last_now;
    assign end_of_frame  = eof_reg;

    `RGB2YUV_ASSERT_NOW(a_chroma_needs_flag, clk, rst_n, busy_reg && chroma_phase_reg, has_chroma_reg)
    `RGB2YUV_ASSERT_NEXT(a_luma_then_chroma, clk, rst_n, out_xfer && !last_now, busy_reg && chroma_phase_reg)
    `RGB2YUV_ASSERT_NOW(a_load_when_free, clk, rst_n, pop, !busy_reg || (out_xfer && last_now))

endmodule

// File: hw/rtl/rgb24_to_yuv420_converter.sv
// Top level of the RGB24 to YUV 4:2:0 converter.
// Depends on rgb2yuv_pkg, rgb2yuv_front, rgb2yuv_queue and rgb2yuv_back.

// Converts RGB24 pixels in raster order to BT.601 studio-range samples tagged with
// their plane. Every pixel gives a luma result; a pixel in an even column then gives
// a Cb result on even rows or a Cr result on odd rows, taken from that pixel alone.
// The frame size registers are clamped to 2..4096 and should be written only while
// the block is idle. A four-entry queue sits between the input counters and the
// result stage, so input transfers continue while results wait. The single result
// register sets the rate: it holds one result at a time, a pixel in an odd column
// gives one result and a pixel in an even column two, and results wait while
// out_ready is low. Each pixel is written into a queue entry and then loaded into
// the result register before its first result is offered.
module rgb24_to_yuv420_converter
    import rgb2yuv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             plane,
    output logic [7:0]             sample_value,
    output logic                   last_of_pixel,
    output logic                   end_of_frame
);

    logic        push;
    pixel_item_t push_item;
    logic        queue_full;
    logic        pop;
    logic        head_valid;
    pixel_item_t head_item;

    rgb2yuv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    rgb2yuv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    rgb2yuv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .plane         (plane),
        .sample_value  (sample_value),
        .last_of_pixel (last_of_pixel),
        .end_of_frame  (end_of_frame)
    );

endmodule

// File: verif/tb_rgb24_to_yuv420_converter.sv
// Self-checking testbench for the RGB24 to YUV 4:2:0 converter: directed table, then random pixels.
// Depends on rgb2yuv_pkg and rgb24_to_yuv420_converter; expected samples come from its own predictor.
`timescale 1ns / 100ps

module tb_rgb24_to_yuv420_converter
    import rgb2yuv_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_CHUNK = 200;
    localparam int CHUNK_COUNT  = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP    = 40;

    typedef struct {
        plane_t     plane;
        logic [7:0] value;
        logic       last;
        logic       eof;
    } sample_t;

    typedef enum {ROW_PIXEL, ROW_WIDTH, ROW_HEIGHT} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        logic [DIM_W-1:0] reg_value;
        bit               typed;
        logic [7:0]       luma;
        logic [7:0]       chroma;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DIM_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             plane;
    logic [7:0]             sample_value;
    logic                   last_of_pixel;
    logic                   end_of_frame;

    sample_t          pending_samples[$];
    sample_t          wanted;
    stim_row_t        directed_rows[$];
    int               mismatch_count;
    int               cycle_count;
    int               send_idle_pct;
    int               recv_idle_pct;
    logic [11:0]      column_pos;
    logic [11:0]      row_pos;
    logic [DIM_W-1:0] width_setting;
    logic [DIM_W-1:0] height_setting;

    rgb24_to_yuv420_converter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .plane         (plane),
        .sample_value  (sample_value),
        .last_of_pixel (last_of_pixel),
        .end_of_frame  (end_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int effective_dim(input logic [DIM_W-1:0] v);
        if (v < MIN_DIMENSION)
            return MIN_DIMENSION;
        if (v > MAX_DIMENSION)
            return MAX_DIMENSION;
        return int'(v);
    endfunction

    function automatic logic [7:0] luma_of(input logic [7:0] r, g, b);
        int s;
        s = 66 * int'(r) + 129 * int'(g) + 25 * int'(b) + 128;
        return 8'((s >>> 8) + 16);
    endfunction

    // Floor division by 256 of a possibly negative sum, then the 128 offset.
    function automatic logic [7:0] chroma_of(input logic [7:0] r, g, b, input bit even_row);
        int s;
        if (even_row)
            s = -38 * int'(r) - 74 * int'(g) + 112 * int'(b) + 128;
        else
            s = 112 * int'(r) - 94 * int'(g) - 18 * int'(b) + 128;
        return 8'((s >>> 8) + 128);
    endfunction

    function automatic logic [7:0] random_component();
        if ($urandom_range(4) == 0)
            return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [DIM_W-1:0] random_dim();
        if ($urandom_range(3) == 0)
            return DIM_W'($urandom_range(8191));
        return DIM_W'($urandom_range(12));
    endfunction

    // Works out the samples of one accepted pixel and advances the raster position.
    task automatic convert_pixel(input logic [7:0] r, g, b, input bit typed,
                                 input logic [7:0] typed_luma, typed_chroma);
        int      w_eff;
        int      h_eff;
        bit      row_end;
        bit      last_row;
        bit      chroma_here;
        bit      even_row;
        sample_t s;
        w_eff       = effective_dim(width_setting);
        h_eff       = effective_dim(height_setting);
        row_end     = (int'(column_pos) + 1 >= w_eff);
        last_row    = (int'(row_pos) + 1 >= h_eff);
        chroma_here = (column_pos[0] == 1'b0);
        even_row    = (row_pos[0] == 1'b0);
        s.plane = PLANE_Y;
        s.value = typed ? typed_luma : luma_of(r, g, b);
        s.last  = !chroma_here;
        s.eof   = row_end && last_row;
        pending_samples.push_back(s);
        if (chroma_here)
        begin
            s.plane = even_row ? PLANE_CB : PLANE_CR;
            s.value = typed ? typed_chroma : chroma_of(r, g, b, even_row);
            s.last  = 1'b1;
            pending_samples.push_back(s);
        end
        if (row_end)
        begin
            column_pos = '0;
            row_pos    = last_row ? 12'd0 : row_pos + 12'd1;
        end
        else
            column_pos = column_pos + 12'd1;
    endtask

    // Offers one pixel, holds it until the transfer and records its samples.
    // Valid is left high afterwards; the next call or a register write decides.
    task automatic send_pixel(input logic [7:0] r, g, b, input bit typed,
                              input logic [7:0] typed_luma, typed_chroma);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        convert_pixel(r, g, b, typed, typed_luma, typed_chroma);
    endtask

    // Registers change only while the block is idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [DIM_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == REG_FRAME_WIDTH)
            width_setting = value;
        else if (index == REG_FRAME_HEIGHT)
            height_setting = value;
    endtask

    task automatic add_pixel(input logic [7:0] r, g, b, input bit typed,
                             input logic [7:0] y, c);
        directed_rows.push_back('{ROW_PIXEL, r, g, b, '0, typed, y, c});
    endtask

    task automatic add_write(input row_kind_t kind, input logic [DIM_W-1:0] value);
        directed_rows.push_back('{kind, 8'd0, 8'd0, 8'd0, value, 1'b0, 8'd0, 8'd0});
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_rgb24_to_yuv420_converter NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_samples.size() == 0)
                begin
                    if (mismatch_count < PRINT_CAP)
                        $display("%0t: unexpected sample plane %0d value %0d last %0b eof %0b",
                                 $time, plane, sample_value, last_of_pixel, end_of_frame);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    wanted = pending_samples.pop_front();
                    if (plane !== wanted.plane || sample_value !== wanted.value ||
                        last_of_pixel !== wanted.last || end_of_frame !== wanted.eof)
                    begin
                        if (mismatch_count < PRINT_CAP)
                            $display({"%0t: expected plane %0d value %0d last %0b eof %0b, ",
                                      "got %0d %0d %0b %0b"},
                                     $time, wanted.plane, wanted.value, wanted.last,
                                     wanted.eof, plane, sample_value,
                                     last_of_pixel, end_of_frame);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_FRAME_WIDTH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        red            = 8'd0;
        green          = 8'd0;
        blue           = 8'd0;
        out_ready      = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 11;
        recv_idle_pct  = 75;
        column_pos     = '0;
        row_pos        = '0;
        width_setting  = DIM_W'(256);
        height_setting = DIM_W'(256);

        // Reset size first, with the primaries and both extremes.
        add_pixel(8'd0,   8'd0,   8'd0,   1'b1, 8'd16,  8'd128);
        add_pixel(8'd255, 8'd255, 8'd255, 1'b1, 8'd235, 8'd0);
        add_pixel(8'd255, 8'd0,   8'd0,   1'b1, 8'd82,  8'd90);
        add_pixel(8'd0,   8'd255, 8'd0,   1'b1, 8'd144, 8'd0);
        add_pixel(8'd0,   8'd0,   8'd255, 1'b1, 8'd41,  8'd240);
        // Sizes below the minimum act as 2; the column is already past the new row end.
        add_write(ROW_WIDTH, 13'd0);
        add_write(ROW_HEIGHT, 13'd1);
        add_pixel(8'd255, 8'd0,   8'd0,   1'b1, 8'd82,  8'd0);
        add_pixel(8'd255, 8'd0,   8'd0,   1'b1, 8'd82,  8'd240);
        add_pixel(8'd255, 8'd255, 8'd255, 1'b1, 8'd235, 8'd0);
        add_pixel(8'd255, 8'd255, 8'd0,   1'b1, 8'd210, 8'd16);
        add_pixel(8'd0,   8'd255, 8'd255, 1'b1, 8'd169, 8'd0);
        add_pixel(8'd0,   8'd255, 8'd255, 1'b1, 8'd169, 8'd16);
        add_pixel(8'd0,   8'd0,   8'd0,   1'b1, 8'd16,  8'd0);
        // Width above the maximum, odd height.
        add_write(ROW_WIDTH, 13'd8191);
        add_write(ROW_HEIGHT, 13'd3);
        add_pixel(8'd18,  8'd200, 8'd77,  1'b0, 8'd0, 8'd0);
        add_pixel(8'd255, 8'd128, 8'd1,   1'b0, 8'd0, 8'd0);
        add_pixel(8'd1,   8'd2,   8'd3,   1'b0, 8'd0, 8'd0);
        add_pixel(8'd128, 8'd128, 8'd128, 1'b0, 8'd0, 8'd0);
        // Odd width shrinks below the current column; height above the maximum.
        add_write(ROW_WIDTH, 13'd3);
        add_write(ROW_HEIGHT, 13'd8191);
        add_pixel(8'd200, 8'd10,  8'd240, 1'b0, 8'd0, 8'd0);
        add_pixel(8'd255, 8'd0,   8'd255, 1'b0, 8'd0, 8'd0);
        add_pixel(8'd85,  8'd170, 8'd51,  1'b0, 8'd0, 8'd0);
        add_pixel(8'd254, 8'd127, 8'd64,  1'b0, 8'd0, 8'd0);
        add_pixel(8'd7,   8'd99,  8'd254, 1'b0, 8'd0, 8'd0);
        add_pixel(8'd160, 8'd32,  8'd8,   1'b0, 8'd0, 8'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_PIXEL:
                    send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                               directed_rows[i].typed, directed_rows[i].luma,
                               directed_rows[i].chroma);
                ROW_WIDTH:
                    write_reg(REG_FRAME_WIDTH, directed_rows[i].reg_value);
                default:
                    write_reg(REG_FRAME_HEIGHT, directed_rows[i].reg_value);
            endcase
        end

        for (int chunk = 0; chunk < CHUNK_COUNT; chunk++)
        begin
            case (chunk)
                0:
                begin
                    w = 13'd2;
                    h = 13'd2;
                end
                1:
                begin
                    w = 13'd4096;
                    h = 13'd4096;
                end
                2:
                begin
                    w = 13'd1;
                    h = 13'd8191;
                end
                default:
                begin
                    w = random_dim();
                    h = random_dim();
                end
            endcase
            write_reg(REG_FRAME_WIDTH, w);
            write_reg(REG_FRAME_HEIGHT, h);
            if (chunk < 4)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 75;
            end
            else if (chunk < 7)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (RANDOM_CHUNK)
                send_pixel(random_component(), random_component(), random_component(),
                           1'b0, 8'd0, 8'd0);
        end

        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_rgb24_to_yuv420_converter OK");
        else
            $display("tb_rgb24_to_yuv420_converter NOT OK");
        $finish;
    end

endmodule

// File: rgb24_to_yuv420_converter.f
+incdir+hw/rtl
hw/rtl/rgb2yuv_pkg.sv
hw/rtl/rgb2yuv_front.sv
hw/rtl/rgb2yuv_queue.sv
hw/rtl/rgb2yuv_back.sv
hw/rtl/rgb24_to_yuv420_converter.sv
verif/tb_rgb24_to_yuv420_converter.sv
